@@ sv/erle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erle_pkg: shared types and constants of the escape RLE track decoder
// Stream phases, status codes and field widths.
// ----------------------------------------------------------------------------
package erle_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SPT_W        = 5;
  localparam int unsigned RUN_LEN_W    = 14;
  localparam int unsigned BLK_LEN_W    = 16;
  localparam logic [7:0]  FILLER_BYTE  = 8'hf6;
  localparam logic [SPT_W-1:0] SPT_RESET = SPT_W'(18);

  typedef enum logic [2:0] {
    PH_LEN_LO = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_DATA   = 3'd3,
    PH_FILL   = 3'd4,
    PH_COUNT  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TRUNC_ESC = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_SHORT     = 3'd4
  } status_e;

  typedef enum logic {
    CMD_BYTE   = 1'b0,
    CMD_UNUSED = 1'b1
  } command_e;

endpackage

@@ sv/escape_rle_track_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_rle_track_decoder: escape-byte run-length track decoder
// Expands packed track blocks into (value, length) run descriptors.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o): one transfer carries either a
//   packed stream byte (command_i = 0) or an unused-track command
//   (command_i = 1). Each used track begins with a little-endian 16-bit
//   block length, then the escape byte, then literals and escape triples
//   (escape, fill value, count).
//   Output channel (out_valid_o / out_stall_i): one transfer per run
//   descriptor, or one status transfer when an error is found. After an
//   error the block stays silent until reset.
//   Config channel (cfg_valid_i / cfg_ready_o): writes sectors_per_track;
//   always ready. Write only while the block is idle.
// Timing
//   Each input transfer is decoded in the cycle it is accepted; its result,
//   if any, appears on the output register in the cycle after. One transfer
//   per cycle is sustained unless the receiver stalls the single output register.
// Reset and stall
//   Reset returns the decoder to waiting for a block length, clears the
//   error flag and sets sectors_per_track to 18. While the output register
//   holds a result and the receiver stalls, in_stall_o is raised; a transfer
//   is still taken in the cycle the held result drains.
// ----------------------------------------------------------------------------
module escape_rle_track_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [erle_pkg::SPT_W-1:0]    cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [7:0]                    packed_byte_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    run_value_o,
  output logic [erle_pkg::RUN_LEN_W-1:0] run_length_o,
  output logic                          track_end_o,
  output logic [2:0]                    status_o
);
  import erle_pkg::*;

  // Architectural state
  logic [SPT_W-1:0]     spt_q;
  phase_e               phase_q, phase_d;
  logic [7:0]           len_lo_q, len_lo_d;
  logic [BLK_LEN_W-1:0] left_q, left_d;
  logic [7:0]           esc_q, esc_d;
  logic [7:0]           fill_q, fill_d;
  logic [RUN_LEN_W-1:0] prod_q, prod_d;
  logic                 failed_q, failed_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           val_q;
  logic [RUN_LEN_W-1:0] rlen_q;
  logic                 end_q;
  status_e              stat_q;

  // Result of the current transfer
  logic                 res_vld;
  logic [7:0]           res_val;
  logic [RUN_LEN_W-1:0] res_len;
  logic                 res_end;
  status_e              res_stat;

  logic                 in_acc;
  logic [RUN_LEN_W-1:0] track;
  logic [BLK_LEN_W-1:0] left_dec;
  logic [BLK_LEN_W-1:0] blk_len;
  logic [RUN_LEN_W:0]   sum_lit;
  logic [RUN_LEN_W:0]   sum_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  // Track size in bytes; fits 14 bits for any 5-bit sector count
  assign track    = RUN_LEN_W'(spt_q * SECTOR_BYTES);
  assign left_dec = left_q - BLK_LEN_W'(1);
  assign blk_len  = {packed_byte_i, len_lo_q};
  assign sum_lit  = {1'b0, prod_q} + (RUN_LEN_W + 1)'(1);
  assign sum_cnt  = {1'b0, prod_q} + (RUN_LEN_W + 1)'(packed_byte_i);

  always_comb begin
    phase_d  = phase_q;
    len_lo_d = len_lo_q;
    left_d   = left_q;
    esc_d    = esc_q;
    fill_d   = fill_q;
    prod_d   = prod_q;
    failed_d = failed_q;
    res_vld  = 1'b0;
    res_val  = '0;
    res_len  = '0;
    res_end  = 1'b0;
    res_stat = ST_OK;

    if (in_acc && !failed_q) begin
      if (command_i == CMD_UNUSED) begin
        // filler run, only between tracks
        if (phase_q == PH_LEN_LO) begin
          res_vld = 1'b1;
          res_val = FILLER_BYTE;
          res_len = track;
          res_end = 1'b1;
        end
      end else begin
        case (phase_q)
          PH_LEN_LO: begin
            len_lo_d = packed_byte_i;
            phase_d  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            left_d = blk_len;
            if (blk_len == '0) begin
              failed_d = 1'b1;
              res_vld  = 1'b1;
              res_stat = ST_EMPTY;
            end else begin
              prod_d  = '0;
              phase_d = PH_ESCAPE;
            end
          end
          PH_ESCAPE: begin
            esc_d   = packed_byte_i;
            left_d  = left_dec;
            phase_d = PH_DATA;
            if (left_dec == '0) begin
              // block holds only the escape: track closes empty, or fails short
              phase_d = PH_LEN_LO;
              res_vld = 1'b1;
              if (prod_q != track) begin
                failed_d = 1'b1;
                res_stat = ST_SHORT;
              end else begin
                prod_d  = '0;
                res_end = 1'b1;
              end
            end
          end
          PH_DATA: begin
            left_d = left_dec;
            if (packed_byte_i == esc_q) begin
              if (left_dec < BLK_LEN_W'(2)) begin
                failed_d = 1'b1;
                res_vld  = 1'b1;
                res_stat = ST_TRUNC_ESC;
              end else begin
                phase_d = PH_FILL;
              end
            end else if (sum_lit > {1'b0, track}) begin
              failed_d = 1'b1;
              res_vld  = 1'b1;
              res_stat = ST_OVERFLOW;
            end else begin
              prod_d  = sum_lit[RUN_LEN_W-1:0];
              res_vld = 1'b1;
              if (left_dec == '0) begin
                phase_d = PH_LEN_LO;
                if (sum_lit[RUN_LEN_W-1:0] != track) begin
                  failed_d = 1'b1;
                  res_stat = ST_SHORT;
                end else begin
                  prod_d  = '0;
                  res_val = packed_byte_i;
                  res_len = RUN_LEN_W'(1);
                  res_end = 1'b1;
                end
              end else begin
                res_val = packed_byte_i;
                res_len = RUN_LEN_W'(1);
              end
            end
          end
          PH_FILL: begin
            fill_d  = packed_byte_i;
            left_d  = left_dec;
            phase_d = PH_COUNT;
          end
          PH_COUNT: begin
            left_d  = left_dec;
            phase_d = PH_DATA;
            if (sum_cnt > {1'b0, track}) begin
              failed_d = 1'b1;
              res_vld  = 1'b1;
              res_stat = ST_OVERFLOW;
            end else begin
              prod_d = sum_cnt[RUN_LEN_W-1:0];
              if (left_dec == '0) begin
                phase_d = PH_LEN_LO;
                res_vld = 1'b1;
                if (sum_cnt[RUN_LEN_W-1:0] != track) begin
                  failed_d = 1'b1;
                  res_stat = ST_SHORT;
                end else begin
                  prod_d  = '0;
                  res_val = fill_q;
                  res_len = RUN_LEN_W'(packed_byte_i);
                  res_end = 1'b1;
                end
              end else if (packed_byte_i != 8'd0) begin
                // zero count mid-block gives no run
                res_vld = 1'b1;
                res_val = fill_q;
                res_len = RUN_LEN_W'(packed_byte_i);
              end
            end
          end
          default: begin
            phase_d = PH_LEN_LO;
          end
        endcase
      end
    end
  end

  // Output register: loads on a result, drains on an unstalled transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc && res_vld && !failed_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q       <= SPT_RESET;
      phase_q     <= PH_LEN_LO;
      len_lo_q    <= '0;
      left_q      <= '0;
      esc_q       <= '0;
      fill_q      <= '0;
      prod_q      <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        spt_q <= cfg_data_i;
      end
      phase_q     <= phase_d;
      len_lo_q    <= len_lo_d;
      left_q      <= left_d;
      esc_q       <= esc_d;
      fill_q      <= fill_d;
      prod_q      <= prod_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_vld && !failed_q) begin
      val_q  <= res_val;
      rlen_q <= res_len;
      end_q  <= res_end;
      stat_q <= res_stat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign run_value_o  = val_q;
  assign run_length_o = rlen_q;
  assign track_end_o  = end_q;
  assign status_o     = stat_q;

  // Error flag is sticky
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q)
    else $error("error flag cleared without reset");

  // A pending error status means the decoder has gone silent
  a_err_sets_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stat_q != ST_OK) |-> failed_q)
    else $error("error status without failed flag");

  // Once failed, no new result enters the output register
  a_silent_after_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !out_valid_q) |=> !out_valid_q)
    else $error("result produced after failure");

  // An error result carries no run and no track end
  a_err_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stat_q != ST_OK) |-> (rlen_q == '0 && !end_q && val_q == 8'd0))
    else $error("error result carries run data");

endmodule
